@@ hw/rtl/mlfq_pkg.sv @@
// ----------------------------------------------------------------------------
// mlfq_pkg
// shared types and codes of the multilevel feedback queue scheduler
// ----------------------------------------------------------------------------
package mlfq_pkg;

  localparam int PID_W   = 8;
  localparam int OUTC_W  = 2;
  localparam int KIND_W  = 3;
  localparam int OLVL_W  = 4;
  localparam int CFG_DW  = 16;
  localparam int CFG_IW  = 1;
  localparam int BP_W    = 16;
  localparam int AL_W    = 4;

  localparam logic [CFG_IW-1:0] REG_BOOST_PERIOD  = 1'd0;
  localparam logic [CFG_IW-1:0] REG_ACTIVE_LEVELS = 1'd1;

  localparam logic FUNC_ADMIT = 1'b0;
  localparam logic FUNC_RUN   = 1'b1;

  localparam logic [OUTC_W-1:0] OUTC_YIELD = 2'd0;
  localparam logic [OUTC_W-1:0] OUTC_FULL  = 2'd1;
  localparam logic [OUTC_W-1:0] OUTC_LAST  = 2'd2;

  localparam logic [BP_W-1:0] BOOST_PERIOD_RST  = 16'd10;
  localparam logic [AL_W-1:0] ACTIVE_LEVELS_RST = 4'd3;

  typedef enum logic [KIND_W-1:0] {
    K_ADMIT  = 3'd0,
    K_STAY   = 3'd1,
    K_DEMOTE = 3'd2,
    K_END    = 3'd3,
    K_BOOST  = 3'd4,
    K_REJECT = 3'd5
  } kind_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LATCH,
    OP_ADMIT,
    OP_SELECT,
    OP_READ,
    OP_POP,
    OP_PUSH,
    OP_DECIDE,
    OP_SCAN,
    OP_MOVE
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic func_run;
    logic run_empty;
    logic boost_moves;
    logic scan_hit;
    logic scan_end;
    logic move_last;
  } dp_stat_t;

endpackage

@@ hw/rtl/multilevel_feedback_queue_scheduler_core.sv @@
// ----------------------------------------------------------------------------
// multilevel_feedback_queue_scheduler_core
// admit: latch, then admit; run: latch, select, read, pop, push, decide
// an empty picked level rejects at read; new starts only while busy is low
// boost walk: scan levels downward, a move for each process found
// reset: synchronous, empties all queues, frees every slot, config to defaults
// results cannot be stalled; each beat is shown for one cycle on out_valid
// ----------------------------------------------------------------------------
module multilevel_feedback_queue_scheduler_core import mlfq_pkg::*; #(
  parameter int MAX_LEVELS = 8,
  parameter int MAX_PROCS  = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  // command channel
  input  logic                start,
  output logic                busy,
  input  logic                in_func,
  input  logic [PID_W-1:0]    in_new_pid,
  input  logic [OUTC_W-1:0]   in_slice_outcome,
  // result channel
  output logic                out_valid,
  output logic [KIND_W-1:0]   out_kind,
  output logic [PID_W-1:0]    out_pid,
  output logic [OLVL_W-1:0]   out_dest_level,
  output logic                out_all_done,
  output logic                out_last,
  // configuration write port
  input  logic                cfg_we,
  input  logic [CFG_IW-1:0]   cfg_index,
  input  logic [CFG_DW-1:0]   cfg_wdata
);

  localparam int LW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;

  logic [BP_W-1:0] boost_period_r;
  logic [AL_W-1:0] active_levels_r;
  logic [LW-1:0]   top_lvl;
  logic [BP_W-1:0] period;
  dp_cmd_t         cmd;
  dp_stat_t        stat;

  // configuration registers; the user writes them only while idle, not enforced
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      boost_period_r  <= BOOST_PERIOD_RST;
      active_levels_r <= ACTIVE_LEVELS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BOOST_PERIOD:  boost_period_r  <= cfg_wdata;
        REG_ACTIVE_LEVELS: active_levels_r <= cfg_wdata[AL_W-1:0];
        default: begin
          boost_period_r <= boost_period_r;
        end
      endcase
    end
  end

  // top level index: zero levels acts as one, clamp to what is built
  always_comb begin
    if (active_levels_r == '0) begin
      top_lvl = '0;
    end else if (int'(active_levels_r) > MAX_LEVELS) begin
      top_lvl = LW'(MAX_LEVELS - 1);
    end else begin
      top_lvl = LW'(int'(active_levels_r) - 1);
    end
  end

  // a zero period boosts after every run step
  assign period = (boost_period_r == '0) ? BP_W'(1) : boost_period_r;

  mlfq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .stat  (stat)
  );

  mlfq_dp #(
    .MAX_LEVELS (MAX_LEVELS),
    .MAX_PROCS  (MAX_PROCS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_func          (in_func),
    .in_new_pid       (in_new_pid),
    .in_slice_outcome (in_slice_outcome),
    .top_lvl          (top_lvl),
    .period           (period),
    .out_valid        (out_valid),
    .out_kind         (out_kind),
    .out_pid          (out_pid),
    .out_dest_level   (out_dest_level),
    .out_all_done     (out_all_done),
    .out_last         (out_last)
  );

endmodule

@@ hw/rtl/mlfq_ctrl.sv @@
// ----------------------------------------------------------------------------
// mlfq_ctrl
// sequencer that steps the datapath through admit, run and boost
// ----------------------------------------------------------------------------
module mlfq_ctrl import mlfq_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  output dp_cmd_t  cmd,
  input  dp_stat_t stat
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_RREAD,
    ST_RPOP,
    ST_RPUSH,
    ST_RDEC,
    ST_BSCAN,
    ST_BMOVE
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r;

  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_NOP;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.op    = OP_LATCH;
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (stat.func_run) begin
          cmd.op    = OP_SELECT;
          state_nxt = ST_RREAD;
        end else begin
          cmd.op    = OP_ADMIT;
          state_nxt = ST_IDLE;
        end
      end
      ST_RREAD: begin
        cmd.op    = OP_READ;
        state_nxt = stat.run_empty ? ST_IDLE : ST_RPOP;
      end
      ST_RPOP: begin
        cmd.op    = OP_POP;
        state_nxt = ST_RPUSH;
      end
      ST_RPUSH: begin
        cmd.op    = OP_PUSH;
        state_nxt = ST_RDEC;
      end
      ST_RDEC: begin
        cmd.op    = OP_DECIDE;
        state_nxt = stat.boost_moves ? ST_BSCAN : ST_IDLE;
      end
      ST_BSCAN: begin
        cmd.op = OP_SCAN;
        if (stat.scan_hit) begin
          state_nxt = ST_BMOVE;
        end else if (stat.scan_end) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_BMOVE: begin
        cmd.op    = OP_MOVE;
        state_nxt = stat.move_last ? ST_IDLE : ST_BSCAN;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= (state_nxt != ST_IDLE);
    end
  end

  assign busy = busy_r;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted beat did not raise busy");

endmodule

@@ hw/rtl/mlfq_dp.sv @@
// ----------------------------------------------------------------------------
// mlfq_dp
// queue storage, level pointers, free map and result registers
// ----------------------------------------------------------------------------
module mlfq_dp import mlfq_pkg::*; #(
  parameter int MAX_LEVELS = 8,
  parameter int MAX_PROCS  = 32
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  dp_cmd_t                                    cmd,
  output dp_stat_t                                   stat,
  input  logic                                       in_func,
  input  logic [PID_W-1:0]                           in_new_pid,
  input  logic [OUTC_W-1:0]                          in_slice_outcome,
  input  logic [((MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1)-1:0] top_lvl,
  input  logic [BP_W-1:0]                            period,
  output logic                                       out_valid,
  output logic [KIND_W-1:0]                          out_kind,
  output logic [PID_W-1:0]                           out_pid,
  output logic [OLVL_W-1:0]                          out_dest_level,
  output logic                                       out_all_done,
  output logic                                       out_last
);

  localparam int LW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  localparam int SW = $clog2(MAX_PROCS);
  localparam int CW = $clog2(MAX_PROCS + 1);
  localparam logic [LW-1:0] LV_BOTTOM = '0;
  localparam logic [LW-1:0] LV_LAST   = LW'(MAX_LEVELS - 1);

  // slot memories
  logic [PID_W-1:0] slot_pid  [MAX_PROCS];
  logic [SW-1:0]    slot_next [MAX_PROCS];

  logic [SW-1:0] head_r [MAX_LEVELS];
  logic [SW-1:0] tail_r [MAX_LEVELS];
  logic [CW-1:0] cnt_r  [MAX_LEVELS];
  logic [MAX_PROCS-1:0] free_r;
  logic [LW-1:0] cursor_r;
  logic [BP_W-1:0] steps_r;

  logic              func_r;
  logic [PID_W-1:0]  npid_r;
  logic [OUTC_W-1:0] outc_r;
  logic [LW-1:0]     lv_r;
  logic [LW-1:0]     dest_r;
  logic [LW-1:0]     src_r;
  logic [SW-1:0]     s_r;
  logic [PID_W-1:0]  pid_r;
  logic [PID_W-1:0]  rd_pid_r;
  logic [SW-1:0]     rd_next_r;

  logic              out_valid_r;
  kind_t             out_kind_r;
  logic [PID_W-1:0]  out_pid_r;
  logic [OLVL_W-1:0] out_lvl_r;
  logic              out_done_r;
  logic              out_last_r;

  logic [MAX_LEVELS-1:0] ne, ne_nt, ne_below;
  logic [SW-1:0]     alloc_s;
  logic              free_empty;
  logic [SW-1:0]     rd_addr;
  logic              push_en, link_en;
  logic [LW-1:0]     push_lv;
  logic [SW-1:0]     push_s;
  logic              is_end;
  logic              boost;
  logic [LW-1:0]     sel_from, cur_from, cur_walk, sel_walk;
  logic [OLVL_W-1:0] top_out;

  // highest nonempty level at or below from, else highest up to top, else top
  function automatic logic [LW-1:0] walk_f(input logic [LW-1:0] from,
                                           input logic [LW-1:0] top,
                                           input logic [MAX_LEVELS-1:0] nem);
    logic [LW-1:0] res;
    res = top;
    for (int i = 0; i < MAX_LEVELS; i++) begin
      if (nem[i] && LW'(i) <= top && LW'(i) > from) res = LW'(i);
    end
    for (int i = 0; i < MAX_LEVELS; i++) begin
      if (nem[i] && LW'(i) <= from) res = LW'(i);
    end
    return res;
  endfunction

  always_comb begin
    for (int i = 0; i < MAX_LEVELS; i++) begin
      ne[i]       = (cnt_r[i] != '0);
      ne_nt[i]    = ne[i] && (LW'(i) != top_lvl);
      ne_below[i] = ne_nt[i] && (LW'(i) < src_r);
    end
  end

  always_comb begin
    alloc_s = '0;
    for (int i = MAX_PROCS - 1; i >= 0; i--) begin
      if (free_r[i]) alloc_s = SW'(i);
    end
  end

  assign free_empty = (free_r == '0);
  assign is_end     = (outc_r >= OUTC_LAST);
  assign boost      = (|ne) && (steps_r >= period);
  assign sel_from   = (cursor_r > top_lvl) ? top_lvl : cursor_r;
  assign sel_walk   = walk_f(sel_from, top_lvl, ne);
  assign cur_from   = (lv_r != LV_BOTTOM) ? lv_r - LW'(1) : top_lvl;
  assign cur_walk   = walk_f(cur_from, top_lvl, ne);
  assign top_out    = OLVL_W'(int'(top_lvl) + 1);

  assign rd_addr = (cmd.op == OP_SCAN) ? head_r[src_r] : head_r[lv_r];

  // one tail push per cycle at most
  always_comb begin
    push_en = 1'b0;
    push_lv = top_lvl;
    push_s  = s_r;
    case (cmd.op)
      OP_ADMIT: begin
        push_en = !free_empty;
        push_s  = alloc_s;
      end
      OP_PUSH: begin
        push_en = !is_end;
        push_lv = dest_r;
      end
      OP_MOVE: begin
        push_en = 1'b1;
      end
      default: begin
        push_en = 1'b0;
      end
    endcase
    link_en = push_en && ne[push_lv];
  end

  always_comb begin
    stat.func_run    = (func_r == FUNC_RUN);
    stat.run_empty   = !ne[lv_r];
    stat.boost_moves = boost && (|ne_nt);
    stat.scan_hit    = ne[src_r] && (src_r != top_lvl);
    stat.scan_end    = (src_r == LV_BOTTOM);
    stat.move_last   = (cnt_r[src_r] == CW'(1)) && !(|ne_below);
  end

  always_ff @(posedge clk) begin
    rd_pid_r  <= slot_pid[rd_addr];
    rd_next_r <= slot_next[rd_addr];
    if (cmd.op == OP_ADMIT && !free_empty) begin
      slot_pid[alloc_s] <= npid_r;
    end
    if (link_en) begin
      slot_next[tail_r[push_lv]] <= push_s;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_LEVELS; i++) begin
        head_r[i] <= '0;
        tail_r[i] <= '0;
        cnt_r[i]  <= '0;
      end
      free_r      <= '1;
      cursor_r    <= LW'(ACTIVE_LEVELS_RST - AL_W'(1));
      steps_r     <= '0;
      func_r      <= FUNC_ADMIT;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (cmd.op)
        OP_LATCH: begin
          func_r <= in_func;
          npid_r <= in_new_pid;
          outc_r <= in_slice_outcome;
        end
        OP_ADMIT: begin
          out_valid_r <= 1'b1;
          out_last_r  <= 1'b1;
          if (free_empty) begin
            out_kind_r <= K_REJECT;
            out_pid_r  <= '0;
            out_lvl_r  <= '0;
            out_done_r <= !(|ne);
          end else begin
            free_r[alloc_s] <= 1'b0;
            out_kind_r <= K_ADMIT;
            out_pid_r  <= npid_r;
            out_lvl_r  <= top_out;
            out_done_r <= 1'b0;
          end
        end
        OP_SELECT: begin
          lv_r <= sel_walk;
        end
        OP_READ: begin
          s_r <= head_r[lv_r];
          if (!ne[lv_r]) begin
            out_valid_r <= 1'b1;
            out_kind_r  <= K_REJECT;
            out_pid_r   <= '0;
            out_lvl_r   <= '0;
            out_done_r  <= !(|ne);
            out_last_r  <= 1'b1;
          end
        end
        OP_POP: begin
          head_r[lv_r] <= rd_next_r;
          cnt_r[lv_r]  <= cnt_r[lv_r] - CW'(1);
          pid_r        <= rd_pid_r;
          if (steps_r != '1) steps_r <= steps_r + BP_W'(1);
          if (is_end) free_r[s_r] <= 1'b1;
          if (outc_r == OUTC_FULL) begin
            dest_r <= (lv_r != LV_BOTTOM) ? lv_r - LW'(1) : LV_BOTTOM;
          end else begin
            dest_r <= lv_r;
          end
        end
        OP_DECIDE: begin
          out_valid_r <= 1'b1;
          out_pid_r   <= pid_r;
          out_done_r  <= !(|ne);
          out_last_r  <= !(boost && (|ne_nt));
          if (is_end) begin
            out_kind_r <= K_END;
            out_lvl_r  <= '0;
          end else begin
            out_kind_r <= (outc_r == OUTC_FULL) ? K_DEMOTE : K_STAY;
            out_lvl_r  <= OLVL_W'(int'(dest_r) + 1);
          end
          if (boost) begin
            steps_r  <= '0;
            cursor_r <= top_lvl;
            src_r    <= LV_LAST;
          end else begin
            cursor_r <= ne[lv_r] ? lv_r : cur_walk;
          end
        end
        OP_SCAN: begin
          s_r <= head_r[src_r];
          if (!(ne[src_r] && src_r != top_lvl) && src_r != LV_BOTTOM) begin
            src_r <= src_r - LW'(1);
          end
        end
        OP_MOVE: begin
          head_r[src_r] <= rd_next_r;
          cnt_r[src_r]  <= cnt_r[src_r] - CW'(1);
          out_valid_r   <= 1'b1;
          out_kind_r    <= K_BOOST;
          out_pid_r     <= rd_pid_r;
          out_lvl_r     <= top_out;
          out_done_r    <= 1'b0;
          out_last_r    <= stat.move_last;
        end
        default: begin
          out_valid_r <= 1'b0;
        end
      endcase
      // tail push, shared by admit, requeue and boost
      if (push_en) begin
        if (!ne[push_lv]) head_r[push_lv] <= push_s;
        tail_r[push_lv] <= push_s;
        cnt_r[push_lv]  <= cnt_r[push_lv] + CW'(1);
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = out_kind_r;
  assign out_pid        = out_pid_r;
  assign out_dest_level = out_lvl_r;
  assign out_all_done   = out_done_r;
  assign out_last       = out_last_r;

  a_boost_not_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == K_BOOST |-> !out_all_done)
    else $error("boost beat flagged all queues empty");

  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == K_REJECT |-> out_pid == '0 && out_dest_level == '0)
    else $error("rejected beat carries id or level");

  a_move_src: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == OP_MOVE |-> src_r != top_lvl && ne[src_r])
    else $error("boost move from top or empty level");

endmodule
